// ===== rtl/core/tmt_pkg.sv =====
// Package for the ternary majority tree update block.
// Holds the beat types, the tree size constants and the microcode table.
// Used by rtl/core/ternary_majority_tree_update.sv.
package tmt_pkg;

    localparam int MAX_LEVELS = 6;
    localparam int LVL_W      = 3;
    localparam int IDX_W      = 10;

    function automatic int pow3_const(input int n);
        int p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 3;
        end
        return p;
    endfunction

    localparam int ROWS   = (pow3_const(MAX_LEVELS) - 1) / 2;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int CNT_W  = $clog2(pow3_const(MAX_LEVELS) + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 13;
    localparam int MUL_W      = 12;
    localparam int PROD_W     = IDX_W + MUL_W;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] leaf_index;
        logic             leaf_value;
    } in_beat_t;

    typedef struct packed {
        logic root_is_a;
        logic index_error;
    } out_beat_t;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_ACCEPT = 3'd1;
    localparam logic [2:0] OP_CHECK  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_WRITE  = 3'd4;
    localparam logic [2:0] OP_EMIT   = 3'd5;
    localparam logic [2:0] OP_NONE   = 3'd6;

    localparam logic [2:0] C_CLR_LAST = 3'd0;
    localparam logic [2:0] C_IN_BEAT  = 3'd1;
    localparam logic [2:0] C_SKIP     = 3'd2;
    localparam logic [2:0] C_ALWAYS   = 3'd3;
    localparam logic [2:0] C_MORE     = 3'd4;
    localparam logic [2:0] C_OUT_FREE = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] cond;
        logic       hold;
        logic [2:0] target;
    } uword_t;

    function automatic uword_t ucode(input logic [2:0] pc);
        uword_t w;
        case (pc)
            ST_CLEAR: w = '{op: OP_CLEAR,  cond: C_CLR_LAST, hold: 1'b1, target: ST_IDLE};
            ST_IDLE:  w = '{op: OP_ACCEPT, cond: C_IN_BEAT,  hold: 1'b1, target: ST_CHECK};
            ST_CHECK: w = '{op: OP_CHECK,  cond: C_SKIP,     hold: 1'b0, target: ST_DONE};
            ST_READ:  w = '{op: OP_READ,   cond: C_ALWAYS,   hold: 1'b0, target: ST_WRITE};
            ST_WRITE: w = '{op: OP_WRITE,  cond: C_MORE,     hold: 1'b0, target: ST_READ};
            ST_DONE:  w = '{op: OP_EMIT,   cond: C_OUT_FREE, hold: 1'b1, target: ST_IDLE};
            default:  w = '{op: OP_NONE,   cond: C_ALWAYS,   hold: 1'b0, target: ST_CLEAR};
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] leaf_count(input logic [LVL_W-1:0] lvl);
        logic [CNT_W-1:0] r;
        int p;
        r = '0;
        p = 1;
        for (int i = 0; i <= MAX_LEVELS; i++) begin
            if (lvl == LVL_W'(i)) begin
                r = CNT_W'(p);
            end
            p = p * 3;
        end
        return r;
    endfunction

    function automatic logic [ROW_AW-1:0] row_base(input logic [LVL_W-1:0] lvl);
        logic [ROW_AW-1:0] r;
        int p;
        r = '0;
        p = 1;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (lvl == LVL_W'(i)) begin
                r = ROW_AW'((p - 1) >> 1);
            end
            p = p * 3;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/tmt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module tmt_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 364
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/ternary_majority_tree_update.sv =====
// Ternary majority tree update: top level, microcoded sequencer and datapath.
// Depends on rtl/core/tmt_pkg.sv and rtl/core/tmt_ram.sv.
// Input beats are taken one at a time; a bad index or depth 0 skips the tree walk, and the next
// beat waits until the result is in the output register, so a stalled result holds the input.
// Reset and each configuration write start a clearing pass over all 364 RAM rows, one row
// per cycle, during which no input beat is taken.
module ternary_majority_tree_update (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tmt_pkg::LVL_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tmt_pkg::in_beat_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output tmt_pkg::out_beat_t        out_data
);

    import tmt_pkg::*;

    logic [2:0]        pc_reg, pc_next;
    logic [ROW_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [LVL_W-1:0]  levels_reg, levels_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [ROW_AW-1:0] addr_reg, addr_next;
    logic [1:0]        slot_reg, slot_next;
    logic              mode_reg, mode_next;
    logic              val_reg, val_next;
    logic              err_reg, err_next;
    logic              first_reg, first_next;
    logic              carry_reg, carry_next;
    logic              root_reg, root_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_reg, out_next;

    uword_t            uw;
    logic              cond_true;
    logic [LVL_W-1:0]  depth;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  quot;
    logic [IDX_W-1:0]  rem_full;
    logic [2:0]        row_rd;
    logic [2:0]        row_wr;
    logic              new_bit;
    logic              maj;
    logic              mem_we;
    logic [ROW_AW-1:0] mem_waddr;
    logic [2:0]        mem_wdata;

    tmt_ram #(
        .WIDTH(3),
        .DEPTH(ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_next),
        .rdata (row_rd)
    );

    assign uw    = ucode(pc_reg);
    assign depth = (levels_reg > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : levels_reg;

    assign prod     = PROD_W'(pos_reg) * PROD_W'(DIV3_MUL);
    assign quot     = IDX_W'(prod >> DIV3_SHIFT);
    assign rem_full = pos_reg - IDX_W'(quot * IDX_W'(3));

    assign new_bit = first_reg ? (mode_reg ? ~row_rd[slot_reg] : val_reg) : carry_reg;

    always_comb
    begin
        row_wr           = row_rd;
        row_wr[slot_reg] = new_bit;
    end

    assign maj = (row_wr[0] & row_wr[1]) | (row_wr[0] & row_wr[2]) | (row_wr[1] & row_wr[2]);

    always_comb
    begin
        case (uw.cond)
            C_CLR_LAST: cond_true = (clr_cnt_reg == ROW_AW'(ROWS - 1));
            C_IN_BEAT:  cond_true = in_valid;
            C_SKIP:     cond_true = err_reg || (level_reg == '0);
            C_ALWAYS:   cond_true = 1'b1;
            C_MORE:     cond_true = (level_reg != LVL_W'(1));
            C_OUT_FREE: cond_true = !out_valid_reg || out_ready;
            default:    cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next        = cond_true ? uw.target : (uw.hold ? pc_reg : pc_reg + 3'd1);
        clr_cnt_next   = clr_cnt_reg;
        levels_next    = levels_reg;
        level_next     = level_reg;
        pos_next       = pos_reg;
        addr_next      = addr_reg;
        slot_next      = slot_reg;
        mode_next      = mode_reg;
        val_next       = val_reg;
        err_next       = err_reg;
        first_next     = first_reg;
        carry_next     = carry_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = row_wr;

        case (uw.op)
            OP_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ROW_AW'(1);
            end
            OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    mode_next  = in_data.mode;
                    val_next   = in_data.leaf_value;
                    pos_next   = in_data.leaf_index;
                    level_next = depth;
                    first_next = 1'b1;
                    err_next   = CMP_W'(in_data.leaf_index) >= CMP_W'(leaf_count(depth));
                end
            end
            OP_CHECK:
            begin
                if (!err_reg && level_reg == '0)
                begin
                    root_next = mode_reg ? ~root_reg : val_reg;
                end
            end
            OP_READ:
            begin
                addr_next = row_base(level_reg - LVL_W'(1)) + ROW_AW'(quot);
                slot_next = rem_full[1:0];
                pos_next  = quot;
            end
            OP_WRITE:
            begin
                mem_we     = 1'b1;
                carry_next = maj;
                first_next = 1'b0;
                level_next = level_reg - LVL_W'(1);
                if (level_reg == LVL_W'(1))
                begin
                    root_next = maj;
                end
            end
            OP_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.root_is_a    = root_reg;
                    out_next.index_error  = err_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_valid)
        begin
            levels_next  = cfg_data;
            pc_next      = ST_CLEAR;
            clr_cnt_next = '0;
            root_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            levels_reg    <= LVL_W'(MAX_LEVELS);
            root_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            clr_cnt_reg   <= clr_cnt_next;
            levels_reg    <= levels_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        pos_reg   <= pos_next;
        addr_reg  <= addr_next;
        slot_reg  <= slot_next;
        mode_reg  <= mode_next;
        val_reg   <= val_next;
        err_reg   <= err_next;
        first_reg <= first_next;
        carry_reg <= carry_next;
        out_reg   <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (uw.op == OP_ACCEPT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !cfg_valid |=> pc_reg == ST_CHECK)
        else $error("accepted beat did not move the sequencer to the check step");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pc_reg) == ST_DONE)
        else $error("result appeared outside the done step");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> mem_waddr <= ROW_AW'(ROWS - 1))
        else $error("RAM write beyond the last row");

    a_write_level: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == ST_WRITE |-> level_reg != '0 && !in_ready)
        else $error("level update with no level left");

endmodule

// ===== bench/tb_ternary_majority_tree_update.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ternary_majority_tree_update: directed table, then random phases.
// Results are compared with typed table values or a bench majority tree; needs rtl/core/tmt_pkg.sv.
module tb_ternary_majority_tree_update;

    import tmt_pkg::*;

    localparam logic MODE_SET    = 1'b0;
    localparam logic MODE_TOGGLE = 1'b1;
    localparam logic LEAF_B      = 1'b0;
    localparam logic LEAF_A      = 1'b1;
    localparam logic ERR_NONE    = 1'b0;
    localparam logic ERR_INDEX   = 1'b1;

    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned END_WAIT    = 2 * MAX_LEVELS + 3 + 10;
    localparam int          PLAN_ROWS   = 23;
    localparam int          PHASES      = 9;
    localparam int          RANDOM_ITEMS = 92;

    typedef struct packed {
        logic             set_depth;
        logic [LVL_W-1:0] depth_code;
        logic             mode;
        logic [IDX_W-1:0] idx;
        logic             value;
        logic             typed;
        logic             want_root;
        logic             want_err;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{1'b0, 3'd0, MODE_SET,    10'd0,    LEAF_A, 1'b1, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd728,  LEAF_B, 1'b1, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd729,  LEAF_A, 1'b1, LEAF_B, ERR_INDEX},
        '{1'b0, 3'd0, MODE_TOGGLE, 10'd1023, LEAF_B, 1'b1, LEAF_B, ERR_INDEX},
        '{1'b0, 3'd0, MODE_TOGGLE, 10'd0,    LEAF_B, 1'b0, LEAF_B, ERR_NONE},
        '{1'b1, 3'd0, MODE_SET,    10'd0,    LEAF_B, 1'b0, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd0,    LEAF_A, 1'b1, LEAF_A, ERR_NONE},
        '{1'b0, 3'd0, MODE_TOGGLE, 10'd0,    LEAF_A, 1'b1, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd1,    LEAF_A, 1'b1, LEAF_B, ERR_INDEX},
        '{1'b1, 3'd7, MODE_SET,    10'd0,    LEAF_B, 1'b0, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd728,  LEAF_A, 1'b1, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd729,  LEAF_A, 1'b1, LEAF_B, ERR_INDEX},
        '{1'b1, 3'd1, MODE_SET,    10'd0,    LEAF_B, 1'b0, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd0,    LEAF_A, 1'b1, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_TOGGLE, 10'd2,    LEAF_B, 1'b1, LEAF_A, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd3,    LEAF_A, 1'b1, LEAF_A, ERR_INDEX},
        '{1'b0, 3'd0, MODE_SET,    10'd2,    LEAF_B, 1'b0, LEAF_B, ERR_NONE},
        '{1'b1, 3'd2, MODE_SET,    10'd0,    LEAF_B, 1'b0, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_TOGGLE, 10'd4,    LEAF_A, 1'b0, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd8,    LEAF_A, 1'b0, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd9,    LEAF_A, 1'b1, LEAF_B, ERR_INDEX},
        '{1'b0, 3'd0, MODE_TOGGLE, 10'd5,    LEAF_B, 1'b0, LEAF_B, ERR_NONE},
        '{1'b0, 3'd0, MODE_SET,    10'd7,    LEAF_A, 1'b0, LEAF_B, ERR_NONE}
    };

    localparam logic [LVL_W-1:0] DEPTH_PLAN [PHASES] = '{
        3'd6, 3'd3, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LVL_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    in_beat_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_beat_t        out_data;

    bit          leaf_store [729];
    bit          node_store [364];
    int          tree_depth;
    out_beat_t   expected_roots [$];
    int unsigned mismatches = 0;
    bit          steady;
    int unsigned hold_requests = 0;

    ternary_majority_tree_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    function automatic int three_pow(input int n);
        int p;
        p = 1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 3;
        end
        return p;
    endfunction

    function automatic bit tree_value(input int lvl, input int pos);
        if (lvl == tree_depth)
        begin
            return leaf_store[pos];
        end
        return node_store[(three_pow(lvl) - 1) / 2 + pos];
    endfunction

    function automatic out_beat_t update_tree(input in_beat_t b);
        out_beat_t r;
        int        pos;
        int        ones;
        if (int'(b.leaf_index) >= three_pow(tree_depth))
        begin
            r.root_is_a   = tree_value(0, 0);
            r.index_error = ERR_INDEX;
            return r;
        end
        if (b.mode == MODE_TOGGLE)
        begin
            leaf_store[b.leaf_index] = ~leaf_store[b.leaf_index];
        end
        else
        begin
            leaf_store[b.leaf_index] = b.leaf_value;
        end
        pos = int'(b.leaf_index);
        for (int lvl = tree_depth - 1; lvl >= 0; lvl--)
        begin
            pos  = pos / 3;
            ones = tree_value(lvl + 1, 3 * pos) + tree_value(lvl + 1, 3 * pos + 1)
                 + tree_value(lvl + 1, 3 * pos + 2);
            node_store[(three_pow(lvl) - 1) / 2 + pos] = (ones >= 2);
        end
        r.root_is_a   = tree_value(0, 0);
        r.index_error = ERR_NONE;
        return r;
    endfunction

    function automatic int low_digit_leaf(input int k);
        int idx;
        idx = 0;
        for (int i = 0; i < tree_depth; i++)
        begin
            idx = idx + ((k >> i) & 1) * three_pow(i);
        end
        return idx;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input in_beat_t b, input bit typed, input out_beat_t typed_want);
        out_beat_t predicted;
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = update_tree(b);
        expected_roots.insert(expected_roots.size(), typed ? typed_want : predicted);
    endtask

    task automatic pause(input int unsigned n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_roots.size() != 0);
    endtask

    task automatic write_depth(input logic [LVL_W-1:0] code);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        tree_depth = (code > MAX_LEVELS) ? MAX_LEVELS : int'(code);
        leaf_store = '{default: 1'b0};
        node_store = '{default: 1'b0};
    endtask

    initial
    begin : result_side
        out_beat_t   want;
        int unsigned stall_left;
        int unsigned holds_served;
        out_ready    = 1'b0;
        stall_left   = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_roots.size() == 0)
                begin
                    $error("result beat with nothing pending: root_is_a %0b index_error %0b",
                           out_data.root_is_a, out_data.index_error);
                    mismatches++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (out_data.root_is_a !== want.root_is_a)
                    begin
                        $error("root_is_a: expected %0b, got %0b",
                               want.root_is_a, out_data.root_is_a);
                        mismatches++;
                    end
                    if (out_data.index_error !== want.index_error)
                    begin
                        $error("index_error: expected %0b, got %0b",
                               want.index_error, out_data.index_error);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served++;
                stall_left   = LONG_HOLD;
                out_ready    <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("tb_ternary_majority_tree_update NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        in_beat_t  b;
        out_beat_t typed_want;
        int        span;
        int        bias;
        int        pick;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        steady       = 1'b0;
        tree_depth   = MAX_LEVELS;
        leaf_store   = '{default: 1'b0};
        node_store   = '{default: 1'b0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].set_depth)
            begin
                write_depth(PLAN[r].depth_code);
            end
            else
            begin
                b.mode                 = PLAN[r].mode;
                b.leaf_index           = PLAN[r].idx;
                b.leaf_value           = PLAN[r].value;
                typed_want.root_is_a   = PLAN[r].want_root;
                typed_want.index_error = PLAN[r].want_err;
                send_item(b, PLAN[r].typed, typed_want);
                pause(pick_gap());
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_depth(DEPTH_PLAN[p]);
            steady = (p % 3 == 1);
            bias   = (p % 3 == 0) ? 85 : ((p % 3 == 1) ? 50 : 15);
            span   = three_pow(tree_depth);
            // A sweep over the leaves whose digits are 0 or 1 drives the root toward A.
            for (int k = 0; k < (1 << tree_depth); k++)
            begin
                b.mode       = MODE_SET;
                b.leaf_index = IDX_W'(low_digit_leaf(k));
                b.leaf_value = ($urandom_range(0, 99) < 90) ? LEAF_A : LEAF_B;
                send_item(b, 1'b0, '0);
                pause(steady ? 0 : pick_gap());
            end
            for (int k = 0; k < RANDOM_ITEMS; k++)
            begin
                if (p == 4 && k == 10)
                begin
                    hold_requests++;
                end
                if (p == 6 && k == 40)
                begin
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    b.leaf_index = IDX_W'($urandom_range(span, 1023));
                end
                else if (pick < 55)
                begin
                    b.leaf_index = IDX_W'(low_digit_leaf($urandom_range(0, (1 << tree_depth) - 1)));
                end
                else
                begin
                    b.leaf_index = IDX_W'($urandom_range(0, span - 1));
                end
                b.mode       = ($urandom_range(0, 99) < 40) ? MODE_TOGGLE : MODE_SET;
                b.leaf_value = ($urandom_range(0, 99) < bias) ? LEAF_A : LEAF_B;
                send_item(b, 1'b0, '0);
                pause(steady ? 0 : pick_gap());
            end
        end

        drain_results();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb_ternary_majority_tree_update OK");
        end
        else
        begin
            $display("tb_ternary_majority_tree_update NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tmt_pkg.sv
rtl/core/tmt_ram.sv
rtl/core/ternary_majority_tree_update.sv
bench/tb_ternary_majority_tree_update.sv
